// File: rtl/dd_pkg.sv
// ----------------------------------------------------------------------------
// dd_pkg: shared types, widths and constants
// Widths of the divergence datapath, mode codes and the log2 table generator.
// ----------------------------------------------------------------------------
`default_nettype none

package dd_pkg;

	localparam int PROB_FRAC_BITS = 16;
	localparam int IN_W     = PROB_FRAC_BITS + 1;
	localparam int XE_W     = IN_W + 1;
	localparam int LOG_FRAC = 16;
	localparam int LOG_W    = 21;
	localparam int DIFF_W   = 22;
	localparam int R_W      = 21;
	localparam int LN2_W    = 16;
	localparam int MAG_W    = XE_W + R_W;
	localparam int TERM_W   = MAG_W + 1;
	localparam int SUM_W    = 48;
	localparam int RES_W    = 32;
	localparam int MODE_W   = 2;

	localparam logic [LN2_W-1:0] LN2_Q16 = 16'd45426;

	localparam logic [MODE_W-1:0] MODE_KL  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_SKL = 2'd1;
	localparam logic [MODE_W-1:0] MODE_JSD = 2'd2;

	localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

	typedef struct packed {
		logic ld_s2;
		logic ld_s3;
	} term_ctl_t;

	// Fractional part of log2(1 + i/2^tb) in Q.16, by repeated squaring in Q2.30.
	function automatic logic [LOG_FRAC-1:0] log_frac(input int tb, input int i);
		logic [63:0]          m;
		logic [LOG_FRAC-1:0]  v;
		m = 64'((64'(1) << tb) + 64'(i)) << (30 - tb);
		v = '0;
		for (int b = 0; b < LOG_FRAC; b++) begin
			m = (m * m) >> 30;
			v = v << 1;
			if (m >= (64'(1) << 31)) begin
				m = m >> 1;
				v[0] = 1'b1;
			end
		end
		return v;
	endfunction

endpackage

`default_nettype wire

// File: rtl/dd_ifs.sv
// ----------------------------------------------------------------------------
// dd_ifs: channel interfaces
// Valid/ready channels for input items, results and the mode register.
// ----------------------------------------------------------------------------
`default_nettype none

interface dd_item_if import dd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [IN_W-1:0]   p_value;
	logic [IN_W-1:0]   q_value;
	logic              last_element;

	modport source(output valid, p_value, q_value, last_element, input ready);
	modport sink(input valid, p_value, q_value, last_element, output ready);
endinterface

interface dd_result_if import dd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [RES_W-1:0]  divergence;
	logic              saturated;

	modport source(output valid, divergence, saturated, input ready);
	modport sink(input valid, divergence, saturated, output ready);
endinterface

interface dd_cfg_if import dd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [MODE_W-1:0] divergence_mode;

	modport source(output valid, divergence_mode, input ready);
	modport sink(input valid, divergence_mode, output ready);
endinterface

`default_nettype wire

// File: rtl/distribution_divergence.sv
// ----------------------------------------------------------------------------
// distribution_divergence: streaming KL, symmetric KL and JS divergence
// Accumulates one category per transfer and emits the divergence on the last.
// ----------------------------------------------------------------------------
// Throughput: one input transfer per cycle, unless a result not yet taken stalls
// the last item at the accumulate. The last item passes the input register, the
// log/ln2 stage and the product stage, then accumulates into the result register.
// Reset clears the mode register to plain KL, both sums, the overflow flag and
// all stage valids; it takes effect at once and needs no clearing pass.
`default_nettype none

module distribution_divergence import dd_pkg::*; #(
	parameter int LOG_TABLE_BITS = 8
) (
	input  wire         clk,
	input  wire         arst_n,
	dd_item_if.sink     item,
	dd_result_if.source result,
	dd_cfg_if.sink      cfg
);

	logic [MODE_W-1:0] mode_q;
	logic [MODE_W-1:0] mode_eff;

	logic              v_s1, v_s2, v_s3;
	logic [IN_W-1:0]   p_s1, q_s1;
	logic              last_s1, last_s2, last_s3;
	logic [MODE_W-1:0] mode_s1, mode_s2, mode_s3;

	logic              rdy1, rdy2, rdy3, acc_ok, take;
	term_ctl_t         ctl;

	logic [IN_W:0]     pq_sum;
	logic [IN_W-1:0]   m;
	logic [IN_W-1:0]   ya, yb;
	logic signed [TERM_W-1:0] term_a_s3, term_b_s3;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_KL;
		end else if (cfg.valid) begin
			mode_q <= cfg.divergence_mode;
		end
	end

	assign mode_eff = (mode_q == MODE_SKL || mode_q == MODE_JSD) ? mode_q : MODE_KL;

	assign acc_ok     = !(last_s3 && result.valid && !result.ready);
	assign take       = v_s3 && acc_ok;
	assign rdy3       = !v_s3 || acc_ok;
	assign rdy2       = !v_s2 || rdy3;
	assign rdy1       = !v_s1 || rdy2;
	assign item.ready = rdy1;
	assign ctl.ld_s2  = rdy2;
	assign ctl.ld_s3  = rdy3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= item.valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			p_s1    <= item.p_value;
			q_s1    <= item.q_value;
			last_s1 <= item.last_element;
			mode_s1 <= mode_eff;
		end
		if (rdy2) begin
			last_s2 <= last_s1;
			mode_s2 <= mode_s1;
		end
		if (rdy3) begin
			last_s3 <= last_s2;
			mode_s3 <= mode_s2;
		end
	end

	always_comb begin
		pq_sum = {1'b0, p_s1} + {1'b0, q_s1};
		m      = pq_sum[IN_W:1];
		ya     = (mode_s1 == MODE_JSD) ? m : q_s1;
		yb     = (mode_s1 == MODE_SKL) ? p_s1 : m;
	end

	dd_term #(
		.LOG_TABLE_BITS(LOG_TABLE_BITS)
	) u_term_a (
		.clk     (clk),
		.ctl     (ctl),
		.x       (p_s1),
		.y       (ya),
		.term_s3 (term_a_s3)
	);

	dd_term #(
		.LOG_TABLE_BITS(LOG_TABLE_BITS)
	) u_term_b (
		.clk     (clk),
		.ctl     (ctl),
		.x       (q_s1),
		.y       (yb),
		.term_s3 (term_b_s3)
	);

	dd_accum u_accum (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.last       (last_s3),
		.mode       (mode_s3),
		.term_a     (term_a_s3),
		.term_b     (term_b_s3),
		.res_ready  (result.ready),
		.res_valid  (result.valid),
		.divergence (result.divergence),
		.saturated  (result.saturated)
	);

endmodule

`default_nettype wire

// File: rtl/dd_log2.sv
// ----------------------------------------------------------------------------
// dd_log2: table-based fixed-point log2
// Leading-one position gives the integer part, a constant table the fraction.
// ----------------------------------------------------------------------------
`default_nettype none

module dd_log2 import dd_pkg::*; #(
	parameter int LOG_TABLE_BITS = 8
) (
	input  wire logic [XE_W-1:0]  v,
	output logic      [LOG_W-1:0] lg
);

	localparam int TBL_SIZE = 1 << LOG_TABLE_BITS;
	localparam int K_W      = $clog2(XE_W);

	logic [LOG_FRAC-1:0]       tbl [TBL_SIZE];
	logic [K_W-1:0]            k;
	logic [XE_W-1:0]           norm;
	logic [LOG_TABLE_BITS-1:0] idx;

	for (genvar i = 0; i < TBL_SIZE; i++) begin : g_tbl
		assign tbl[i] = log_frac(LOG_TABLE_BITS, i);
	end

	always_comb begin
		k = '0;
		for (int j = 0; j < XE_W; j++) begin
			if (v[j]) begin
				k = K_W'(j);
			end
		end
	end

	assign norm = v << (K_W'(XE_W - 1) - k);
	assign idx  = norm[XE_W-2 -: LOG_TABLE_BITS];
	assign lg   = (LOG_W'(k) << LOG_FRAC) + LOG_W'(tbl[idx]);

endmodule

`default_nettype wire

// File: rtl/dd_term.sv
// ----------------------------------------------------------------------------
// dd_term: pointwise term x*ln(x/y)
// Log difference and ln2 scaling in one stage, the x product in the next.
// ----------------------------------------------------------------------------
`default_nettype none

module dd_term import dd_pkg::*; #(
	parameter int LOG_TABLE_BITS = 8
) (
	input  wire                          clk,
	input  wire term_ctl_t               ctl,
	input  wire logic [IN_W-1:0]         x,
	input  wire logic [IN_W-1:0]         y,
	output logic signed [TERM_W-1:0]     term_s3
);

	localparam int SHIFT = PROB_FRAC_BITS - 8;

	logic [XE_W-1:0]          xe;
	logic [XE_W-1:0]          ye;
	logic [LOG_W-1:0]         lx;
	logic [LOG_W-1:0]         ly;
	logic signed [DIFF_W-1:0] d;
	logic                     neg;
	logic [LOG_W-1:0]         ad;
	logic [LOG_W+LN2_W-1:0]   prod;

	logic [R_W-1:0]           r_s2;
	logic                     neg_s2;
	logic [XE_W-1:0]          xe_s2;

	logic [MAG_W-1:0]         mag;
	logic [TERM_W-1:0]        mag_ext;

	assign xe = {1'b0, x} + XE_W'(1);
	assign ye = {1'b0, y} + XE_W'(1);

	dd_log2 #(.LOG_TABLE_BITS(LOG_TABLE_BITS)) u_log_x (.v(xe), .lg(lx));
	dd_log2 #(.LOG_TABLE_BITS(LOG_TABLE_BITS)) u_log_y (.v(ye), .lg(ly));

	always_comb begin
		d    = $signed({1'b0, lx}) - $signed({1'b0, ly});
		neg  = d[DIFF_W-1];
		ad   = neg ? LOG_W'(-d) : LOG_W'(d);
		prod = (LOG_W+LN2_W)'(ad) * (LOG_W+LN2_W)'(LN2_Q16);
	end

	always_ff @(posedge clk) begin
		if (ctl.ld_s2) begin
			r_s2   <= prod[LN2_W +: R_W];
			neg_s2 <= neg;
			xe_s2  <= xe;
		end
	end

	always_comb begin
		mag     = (MAG_W'(xe_s2) * MAG_W'(r_s2)) >> SHIFT;
		mag_ext = {1'b0, mag};
	end

	always_ff @(posedge clk) begin
		if (ctl.ld_s3) begin
			term_s3 <= neg_s2 ? -$signed(mag_ext) : $signed(mag_ext);
		end
	end

endmodule

`default_nettype wire

// File: rtl/dd_accum.sv
// ----------------------------------------------------------------------------
// dd_accum: saturating accumulators and result register
// Adds the terms, closes the vector on the last item and holds the result.
// ----------------------------------------------------------------------------
`default_nettype none

module dd_accum import dd_pkg::*; (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       take,
	input  wire                       last,
	input  wire logic [MODE_W-1:0]    mode,
	input  wire logic signed [TERM_W-1:0] term_a,
	input  wire logic signed [TERM_W-1:0] term_b,
	input  wire                       res_ready,
	output logic                      res_valid,
	output logic [RES_W-1:0]          divergence,
	output logic                      saturated
);

	logic signed [SUM_W-1:0] first_sum_q;
	logic signed [SUM_W-1:0] second_sum_q;
	logic                    overflow_q;

	logic signed [SUM_W:0]   raw_a;
	logic signed [SUM_W:0]   raw_b;
	logic                    ovf_a;
	logic                    ovf_b;
	logic signed [SUM_W-1:0] nf;
	logic signed [SUM_W-1:0] ns;
	logic                    ovf_new;
	logic [SUM_W-1:0]        pos_a;
	logic [SUM_W-1:0]        pos_b;
	logic [SUM_W:0]          pair;
	logic [SUM_W-1:0]        res;
	logic                    big;

	always_comb begin
		raw_a = {first_sum_q[SUM_W-1], first_sum_q} + (SUM_W+1)'(term_a);
		raw_b = {second_sum_q[SUM_W-1], second_sum_q} + (SUM_W+1)'(term_b);
		ovf_a = raw_a[SUM_W] ^ raw_a[SUM_W-1];
		ovf_b = (mode != MODE_KL) && (raw_b[SUM_W] ^ raw_b[SUM_W-1]);
		nf    = ovf_a ? (raw_a[SUM_W] ? SUM_MIN : SUM_MAX) : raw_a[SUM_W-1:0];
		if (mode == MODE_KL) begin
			ns = second_sum_q;
		end else begin
			ns = ovf_b ? (raw_b[SUM_W] ? SUM_MIN : SUM_MAX) : raw_b[SUM_W-1:0];
		end
		ovf_new = overflow_q | ovf_a | ovf_b;
		pos_a   = nf[SUM_W-1] ? '0 : nf;
		pos_b   = ns[SUM_W-1] ? '0 : ns;
		pair    = {1'b0, pos_a} + {1'b0, pos_b};
		res     = (mode == MODE_KL) ? pos_a : pair[SUM_W:1];
		big     = |res[SUM_W-1:RES_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_sum_q  <= '0;
			second_sum_q <= '0;
			overflow_q   <= 1'b0;
		end else if (take) begin
			if (last) begin
				first_sum_q  <= '0;
				second_sum_q <= '0;
				overflow_q   <= 1'b0;
			end else begin
				first_sum_q  <= nf;
				second_sum_q <= ns;
				overflow_q   <= ovf_new;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (take && last) begin
			res_valid <= 1'b1;
		end else if (res_ready) begin
			res_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && last) begin
			divergence <= big ? '1 : res[RES_W-1:0];
			saturated  <= ovf_new | big;
		end
	end

endmodule

`default_nettype wire
